/* design/ir_pulse_distance_command_decoder_defines.svh */
// ----------------------------------------------------------------------------
// ir_pulse_distance_command_decoder_defines
// assertion macros shared by the decoder modules
// ----------------------------------------------------------------------------
`ifndef IR_PULSE_DISTANCE_COMMAND_DECODER_DEFINES_SVH
`define IR_PULSE_DISTANCE_COMMAND_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define IRCD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define IRCD_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define IRCD_ASSERT(lbl, clk, rst, prop, msg)
`define IRCD_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

/* design/ircd_pkg.sv */
// ----------------------------------------------------------------------------
// ircd_pkg
// shared widths, register indices, reset values and beat types
// ----------------------------------------------------------------------------
package ircd_pkg;

   localparam int REG_W          = 20;
   localparam int CODE_W         = 8;
   localparam int CMD_BITS       = 8;
   localparam int CMD_SEL_W      = $clog2(CMD_BITS);
   localparam int FIRST_BIT_EDGE = 17;
   localparam int CSR_IDX_W      = 3;

   localparam int COUNT_WIDTH_DEF = 20;
   localparam int EDGE_SLOTS_DEF  = 64;

   localparam logic [CSR_IDX_W-1:0] REG_HEADER_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEADER_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_MIN      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ONE_MAX      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_TIMEOUT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_ON_CODE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_OFF_CODE     = 3'd6;

   localparam logic [REG_W-1:0]  HEADER_MIN_RST   = 20'd10000;
   localparam logic [REG_W-1:0]  HEADER_MAX_RST   = 20'd14000;
   localparam logic [REG_W-1:0]  ONE_MIN_RST      = 20'd2000;
   localparam logic [REG_W-1:0]  ONE_MAX_RST      = 20'd2300;
   localparam logic [REG_W-1:0]  IDLE_TIMEOUT_RST = 20'd1000000;
   localparam logic [CODE_W-1:0] ON_CODE_RST      = 8'd220;
   localparam logic [CODE_W-1:0] OFF_CODE_RST     = 8'd218;

   typedef struct packed {
      logic [REG_W-1:0]  header_min;
      logic [REG_W-1:0]  header_max;
      logic [REG_W-1:0]  one_min;
      logic [REG_W-1:0]  one_max;
      logic [REG_W-1:0]  idle_timeout;
      logic [CODE_W-1:0] on_code;
      logic [CODE_W-1:0] off_code;
   } cfg_type;

   typedef struct packed {
      logic              frame_ok;
      logic [CODE_W-1:0] command;
      logic              led_on;
   } rsp_type;

endpackage

/* design/ir_pulse_distance_command_decoder.sv */
// ----------------------------------------------------------------------------
// ir_pulse_distance_command_decoder
// pulse-distance remote decoder: one timer tick per req beat, one rsp beat
// per closed frame. the closing tick's result is registered in the result buffer.
// throughput is one tick per cycle, set by the single-pass frame logic;
// req_ready drops only when both result buffer entries wait on rsp_ready.
// synchronous reset restores register defaults and clears frame and led state.
// ----------------------------------------------------------------------------
module ir_pulse_distance_command_decoder #(
   parameter int COUNT_WIDTH = ircd_pkg::COUNT_WIDTH_DEF,
   parameter int EDGE_SLOTS  = ircd_pkg::EDGE_SLOTS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_edge_seen,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_frame_ok,
   output logic [ircd_pkg::CODE_W-1:0]    rsp_command,
   output logic                           rsp_led_on,
   input  logic                           csr_wr_en,
   input  logic [ircd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ircd_pkg::REG_W-1:0]     csr_wdata
);
   import ircd_pkg::*;

   cfg_type cfg;
   rsp_type rslt;
   rsp_type rsp_data;
   logic    rslt_valid;
   logic    tick_fire;
   logic    has_room;

   assign req_ready = has_room;
   assign tick_fire = req_valid && req_ready;

   ircd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ircd_frame #(
      .COUNT_WIDTH (COUNT_WIDTH),
      .EDGE_SLOTS  (EDGE_SLOTS)
   ) u_frame (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .tick_fire  (tick_fire),
      .edge_seen  (req_edge_seen),
      .rslt_valid (rslt_valid),
      .rslt       (rslt)
   );

   ircd_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rslt_valid),
      .push_data (rslt),
      .has_room  (has_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_frame_ok = rsp_data.frame_ok;
   assign rsp_command  = rsp_data.command;
   assign rsp_led_on   = rsp_data.led_on;

endmodule

/* design/ircd_csr.sv */
// ----------------------------------------------------------------------------
// ircd_csr
// configuration registers, written through the plain write port
// ----------------------------------------------------------------------------
module ircd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [ircd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ircd_pkg::REG_W-1:0]     csr_wdata,
   output ircd_pkg::cfg_type              cfg
);
   import ircd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_HEADER_MIN:   cfg_in.header_min   = csr_wdata;
            REG_HEADER_MAX:   cfg_in.header_max   = csr_wdata;
            REG_ONE_MIN:      cfg_in.one_min      = csr_wdata;
            REG_ONE_MAX:      cfg_in.one_max      = csr_wdata;
            REG_IDLE_TIMEOUT: cfg_in.idle_timeout = csr_wdata;
            REG_ON_CODE:      cfg_in.on_code      = csr_wdata[CODE_W-1:0];
            REG_OFF_CODE:     cfg_in.off_code     = csr_wdata[CODE_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_min   <= HEADER_MIN_RST;
         cfg_ff.header_max   <= HEADER_MAX_RST;
         cfg_ff.one_min      <= ONE_MIN_RST;
         cfg_ff.one_max      <= ONE_MAX_RST;
         cfg_ff.idle_timeout <= IDLE_TIMEOUT_RST;
         cfg_ff.on_code      <= ON_CODE_RST;
         cfg_ff.off_code     <= OFF_CODE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/ircd_frame.sv */
// ----------------------------------------------------------------------------
// ircd_frame
// per-tick frame tracking: interval timing, header and bit decode, led update
// ----------------------------------------------------------------------------
`include "ir_pulse_distance_command_decoder_defines.svh"

module ircd_frame #(
   parameter int COUNT_WIDTH = ircd_pkg::COUNT_WIDTH_DEF,
   parameter int EDGE_SLOTS  = ircd_pkg::EDGE_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ircd_pkg::cfg_type cfg,
   input  logic              tick_fire,
   input  logic              edge_seen,
   output logic              rslt_valid,
   output ircd_pkg::rsp_type rslt
);
   import ircd_pkg::*;

   localparam int EIW   = $clog2(EDGE_SLOTS);
   localparam int CMP_W = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MASK = '1;
   localparam logic [EIW-1:0] EDGE_LAST = EIW'(EDGE_SLOTS - 1);
   localparam logic [EIW-1:0] BIT_FIRST = EIW'(FIRST_BIT_EDGE);
   localparam logic [EIW-1:0] BIT_END   = EIW'(FIRST_BIT_EDGE + CMD_BITS);

   logic                   in_frame_ff, in_frame_in;
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [EIW-1:0]         edge_index_ff, edge_index_in;
   logic                   header_good_ff, header_good_in;
   logic [CMD_BITS-1:0]    command_bits_ff, command_bits_in;
   logic                   led_state_ff, led_state_in;

   logic [COUNT_WIDTH-1:0] elapsed;
   logic [CMP_W-1:0]       elapsed_x;
   logic                   timeout_hit;
   logic                   header_hit;
   logic                   one_hit;
   logic                   bit_slot;
   logic [CMD_SEL_W-1:0]   bit_sel;
   logic [CODE_W-1:0]      cmd_out;
   logic                   led_next;

   always_comb begin
      elapsed     = (tick_count_ff == COUNT_MASK) ? COUNT_MASK
                                                  : tick_count_ff + COUNT_WIDTH'(1);
      elapsed_x   = CMP_W'(elapsed);
      timeout_hit = elapsed_x >= CMP_W'(cfg.idle_timeout);
      header_hit  = (elapsed_x >= CMP_W'(cfg.header_min)) &&
                    (elapsed_x <= CMP_W'(cfg.header_max));
      one_hit     = (elapsed_x >= CMP_W'(cfg.one_min)) &&
                    (elapsed_x <= CMP_W'(cfg.one_max));
      bit_slot    = (edge_index_ff >= BIT_FIRST) && (edge_index_ff < BIT_END);
      bit_sel     = CMD_SEL_W'(edge_index_ff - BIT_FIRST);

      cmd_out  = header_good_ff ? command_bits_ff : '0;
      led_next = led_state_ff;
      if (header_good_ff) begin
         if (cmd_out == cfg.on_code) begin
            led_next = 1'b1;
         end else if (cmd_out == cfg.off_code) begin
            led_next = 1'b0;
         end
      end

      rslt_valid       = tick_fire && in_frame_ff && timeout_hit;
      rslt.frame_ok    = header_good_ff;
      rslt.command     = cmd_out;
      rslt.led_on      = led_next;

      in_frame_in     = in_frame_ff;
      tick_count_in   = tick_count_ff;
      edge_index_in   = edge_index_ff;
      header_good_in  = header_good_ff;
      command_bits_in = command_bits_ff;
      led_state_in    = led_state_ff;

      if (tick_fire) begin
         if (in_frame_ff) begin
            if (timeout_hit) begin
               led_state_in  = led_next;
               in_frame_in   = edge_seen;
               tick_count_in = '0;
               edge_index_in = '0;
               if (edge_seen) begin
                  header_good_in  = 1'b0;
                  command_bits_in = '0;
               end
            end else if (edge_seen) begin
               if (edge_index_ff == '0) begin
                  header_good_in = header_hit;
               end else if (bit_slot) begin
                  command_bits_in[bit_sel] = one_hit;
               end
               if (edge_index_ff != EDGE_LAST) begin
                  edge_index_in = edge_index_ff + EIW'(1);
               end
               tick_count_in = '0;
            end else begin
               tick_count_in = elapsed;
            end
         end else if (edge_seen) begin
            in_frame_in     = 1'b1;
            tick_count_in   = '0;
            edge_index_in   = '0;
            header_good_in  = 1'b0;
            command_bits_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         tick_count_ff   <= '0;
         edge_index_ff   <= '0;
         header_good_ff  <= 1'b0;
         command_bits_ff <= '0;
         led_state_ff    <= 1'b0;
      end else begin
         in_frame_ff     <= in_frame_in;
         tick_count_ff   <= tick_count_in;
         edge_index_ff   <= edge_index_in;
         header_good_ff  <= header_good_in;
         command_bits_ff <= command_bits_in;
         led_state_ff    <= led_state_in;
      end
   end

   `IRCD_ASSERT(a_idle_cleared, clock, reset, !in_frame_ff |-> (tick_count_ff == '0 && edge_index_ff == '0), "idle state not cleared")
   `IRCD_ASSERT(a_close_restarts, clock, reset, rslt_valid |=> (tick_count_ff == '0 && edge_index_ff == '0), "frame close left timing state")
   `IRCD_ASSERT(a_led_on_result, clock, reset, rslt_valid |=> (led_state_ff == $past(rslt.led_on)), "led state differs from reported")

endmodule

/* design/ircd_rsp_buf.sv */
// ----------------------------------------------------------------------------
// ircd_rsp_buf
// two-entry result buffer between the frame logic and the rsp channel
// ----------------------------------------------------------------------------
`include "ir_pulse_distance_command_decoder_defines.svh"

module ircd_rsp_buf (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ircd_pkg::rsp_type push_data,
   output logic              has_room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ircd_pkg::rsp_type rsp_data
);
   import ircd_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   always_comb begin
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign has_room  = count_ff != 2'd2;
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_data  = slot_ff[rd_ptr_ff];

   `IRCD_NEVER(a_no_overflow, clock, reset, push && !has_room, "push into full buffer")
   `IRCD_NEVER(a_count_range, clock, reset, count_ff == 2'd3, "buffer count out of range")
   `IRCD_ASSERT(a_pop_drains, clock, reset, (pop && !push) |=> (count_ff == $past(count_ff) - 2'd1), "pop did not drain")

endmodule

/* verif/ir_pulse_distance_command_decoder_tb.sv */
// ----------------------------------------------------------------------------
// ir_pulse_distance_command_decoder_tb
// feeds timer ticks with falling-edge flags through the req channel and checks
// every closed-frame beat on the rsp channel against a cycle-free frame
// decoder kept in step with each accepted tick. a table of directed frames
// runs first, then fixed corner settings (wide, empty and clashing windows,
// zero, unit and maximum timeouts), then random settings with mostly
// well-formed frames mixed with short, long, chained and noisy traffic.
// both channels idle and stall at random, with spells of full rate.
// ----------------------------------------------------------------------------
module ir_pulse_distance_command_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ircd_pkg::*;

   localparam int EDGE_W        = $clog2(EDGE_SLOTS_DEF);
   localparam int EDGE_LAST     = EDGE_SLOTS_DEF - 1;
   localparam int TICK_GOAL     = 1050;
   localparam int DIRECTED_ROWS = 13;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;

   localparam logic [7:0] FULL_FRAME = 8'd25;
   localparam logic [7:0] FULL_TAIL  = 8'd7;

   typedef struct packed {
      logic [7:0] hdr;
      logic [7:0] n_iv;
      logic [7:0] cmd;
      logic [7:0] tail;
      logic       known;
      rsp_type    want;
   } frame_row_type;

   // header window 3..5, one window 2..3, timeout 7, codes left at reset
   localparam frame_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'd0, 8'd0,       8'h00,       FULL_TAIL, 1'b1, '{1'b0, 8'h00,       1'b0}},
      '{8'd4, FULL_FRAME, ON_CODE_RST,  FULL_TAIL, 1'b1, '{1'b1, ON_CODE_RST,  1'b1}},
      '{8'd4, FULL_FRAME, 8'h00,       FULL_TAIL, 1'b1, '{1'b1, 8'h00,       1'b1}},
      '{8'd4, FULL_FRAME, 8'hFF,       FULL_TAIL, 1'b1, '{1'b1, 8'hFF,       1'b1}},
      '{8'd4, FULL_FRAME, OFF_CODE_RST, FULL_TAIL, 1'b1, '{1'b1, OFF_CODE_RST, 1'b0}},
      '{8'd2, FULL_FRAME, ON_CODE_RST,  FULL_TAIL, 1'b1, '{1'b0, 8'h00,       1'b0}},
      '{8'd6, FULL_FRAME, ON_CODE_RST,  FULL_TAIL, 1'b1, '{1'b0, 8'h00,       1'b0}},
      '{8'd3, FULL_FRAME, ON_CODE_RST,  FULL_TAIL, 1'b1, '{1'b1, ON_CODE_RST,  1'b1}},
      '{8'd5, FULL_FRAME, OFF_CODE_RST, FULL_TAIL, 1'b1, '{1'b1, OFF_CODE_RST, 1'b0}},
      // cut short after command bit 2, upper bits must read back as zero
      '{8'd4, 8'd20,      8'hFF,       FULL_TAIL, 1'b0, '{1'b0, 8'h00,       1'b0}},
      // edge index runs into saturation
      '{8'd4, 8'd70,      8'h3C,       FULL_TAIL, 1'b0, '{1'b0, 8'h00,       1'b0}},
      // next frame opens on the closing tick
      '{8'd4, FULL_FRAME, 8'hC3,       8'd6,      1'b0, '{1'b0, 8'h00,       1'b0}},
      '{8'd4, FULL_FRAME, ON_CODE_RST,  FULL_TAIL, 1'b0, '{1'b0, 8'h00,       1'b0}}
   };

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_edge_seen = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_frame_ok;
   logic [CODE_W-1:0]    rsp_command;
   logic                 rsp_led_on;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = REG_HEADER_MIN;
   logic [REG_W-1:0]     csr_wdata = '0;

   ir_pulse_distance_command_decoder i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_edge_seen (req_edge_seen),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_frame_ok  (rsp_frame_ok),
      .rsp_command   (rsp_command),
      .rsp_led_on    (rsp_led_on),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #1 clock = ~clock;

   // register mirror and frame decoder state
   cfg_type                cfg = '{HEADER_MIN_RST, HEADER_MAX_RST, ONE_MIN_RST, ONE_MAX_RST,
                                   IDLE_TIMEOUT_RST, ON_CODE_RST, OFF_CODE_RST};
   logic                   dec_open = 1'b0;
   logic [REG_W-1:0]       dec_ticks = '0;
   logic [EDGE_W-1:0]      dec_edges = '0;
   logic                   dec_hdr_ok = 1'b0;
   logic [CMD_BITS-1:0]    dec_bits = '0;
   logic                   dec_led = 1'b0;

   rsp_type                pending_frames[$];
   int unsigned            errors = 0;
   int unsigned            ticks_sent = 0;
   int unsigned            frames_closed = 0;
   int unsigned            frames_good = 0;
   int unsigned            settings_count = 0;
   int unsigned            rsp_hold = 0;
   bit                     steady = 1'b0;

   task automatic decode_tick(input logic fall);
      logic [REG_W-1:0] elapsed;
      rsp_type          res;
      bit               spent;
      spent = 1'b0;
      if (dec_open) begin
         elapsed = (dec_ticks == '1) ? dec_ticks : dec_ticks + 1'b1;
         if (elapsed >= cfg.idle_timeout) begin
            res.frame_ok = dec_hdr_ok;
            res.command  = dec_hdr_ok ? dec_bits : '0;
            if (dec_hdr_ok) begin
               if (res.command == cfg.on_code) begin
                  dec_led = 1'b1;
               end else if (res.command == cfg.off_code) begin
                  dec_led = 1'b0;
               end
            end
            res.led_on = dec_led;
            pending_frames.push_back(res);
            frames_closed++;
            if (dec_hdr_ok) frames_good++;
            dec_open  = 1'b0;
            dec_ticks = '0;
            dec_edges = '0;
         end else begin
            spent = 1'b1;
            if (fall) begin
               if (dec_edges == 0) begin
                  dec_hdr_ok = elapsed >= cfg.header_min && elapsed <= cfg.header_max;
               end else if (dec_edges >= FIRST_BIT_EDGE &&
                            dec_edges < FIRST_BIT_EDGE + CMD_BITS) begin
                  dec_bits[dec_edges - FIRST_BIT_EDGE] =
                     elapsed >= cfg.one_min && elapsed <= cfg.one_max;
               end
               if (dec_edges != EDGE_LAST) dec_edges++;
               dec_ticks = '0;
            end else begin
               dec_ticks = elapsed;
            end
         end
      end
      if (!spent && fall) begin
         dec_open   = 1'b1;
         dec_ticks  = '0;
         dec_edges  = '0;
         dec_hdr_ok = 1'b0;
         dec_bits   = '0;
      end
   endtask

   task automatic drive_tick(input logic fall);
      int unsigned gap;
      gap = steady ? 0 : $urandom_range(4, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_edge_seen <= fall;
      do @(posedge clock); while (!req_ready);
      decode_tick(fall);
      ticks_sent++;
   endtask

   // interval in 1..lim, inside or outside lo..hi where that is possible
   function automatic int unsigned pick_len(bit in_win, int unsigned lo, int unsigned hi,
                                            int unsigned lim);
      int unsigned a;
      int unsigned b;
      a = (lo < 1) ? 1 : lo;
      b = (hi > lim) ? lim : hi;
      if (in_win && a <= b) return $urandom_range(b, a);
      if (!in_win && lo > 1 && (hi >= lim || $urandom_range(1, 0) == 1))
         return $urandom_range((lo - 1 > lim) ? lim : lo - 1, 1);
      if (!in_win && hi < lim) return $urandom_range(lim, hi + 1);
      return $urandom_range(lim, 1);
   endfunction

   function automatic int unsigned longest_gap();
      if (cfg.idle_timeout < 2) return 1;
      if (cfg.idle_timeout > 9) return 8;
      return 32'(cfg.idle_timeout) - 1;
   endfunction

   task automatic send_frame(input int unsigned hdr, input int unsigned n_iv,
                             input logic [7:0] cmd, input int unsigned tail);
      int unsigned lim;
      int unsigned len;
      lim = longest_gap();
      drive_tick(1'b1);
      for (int i = 0; i < n_iv; i++) begin
         if (i == 0) begin
            len = hdr;
         end else if (i >= FIRST_BIT_EDGE && i < FIRST_BIT_EDGE + CMD_BITS) begin
            len = pick_len(cmd[i - FIRST_BIT_EDGE], 32'(cfg.one_min), 32'(cfg.one_max), lim);
         end else begin
            len = 1;
         end
         repeat (len - 1) drive_tick(1'b0);
         drive_tick(1'b1);
      end
      repeat (tail) drive_tick(1'b0);
   endtask

   task automatic random_frame();
      int unsigned lim;
      int unsigned hdr;
      int unsigned n_iv;
      logic [7:0]  cmd;
      lim = longest_gap();
      hdr = pick_len($urandom_range(9, 0) != 0, 32'(cfg.header_min), 32'(cfg.header_max),
                     lim);
      case ($urandom_range(19, 0))
         0, 1: n_iv = $urandom_range(16, 0);
         2, 3: n_iv = $urandom_range(24, 17);
         4, 5: n_iv = $urandom_range(40, 26);
         6: n_iv = $urandom_range(72, 64);
         default: n_iv = 32'(FULL_FRAME);
      endcase
      case ($urandom_range(5, 0))
         0, 1: cmd = cfg.on_code;
         2: cmd = cfg.off_code;
         default: cmd = 8'($urandom);
      endcase
      send_frame(hdr, n_iv, cmd, lim + $urandom_range(4, 0));
   endtask

   task automatic noise_burst();
      int unsigned n;
      int unsigned k;
      n = $urandom_range(40, 5);
      k = $urandom_range(6, 0);
      repeat (n) drive_tick($urandom_range(k, 0) == 0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         REG_HEADER_MIN:   cfg.header_min   = value;
         REG_HEADER_MAX:   cfg.header_max   = value;
         REG_ONE_MIN:      cfg.one_min      = value;
         REG_ONE_MAX:      cfg.one_max      = value;
         REG_IDLE_TIMEOUT: cfg.idle_timeout = value;
         REG_ON_CODE:      cfg.on_code      = value[CODE_W-1:0];
         REG_OFF_CODE:     cfg.off_code     = value[CODE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input cfg_type c, input bit keep_codes);
      logic [REG_W-CODE_W-1:0] junk;
      settle();
      if ($urandom_range(3, 0) == 0) write_reg(REG_SPARE, REG_W'($urandom));
      write_reg(REG_HEADER_MIN, c.header_min);
      write_reg(REG_HEADER_MAX, c.header_max);
      write_reg(REG_ONE_MIN, c.one_min);
      write_reg(REG_ONE_MAX, c.one_max);
      write_reg(REG_IDLE_TIMEOUT, c.idle_timeout);
      if (!keep_codes) begin
         junk = (REG_W-CODE_W)'($urandom);
         write_reg(REG_ON_CODE, {junk, c.on_code});
         junk = (REG_W-CODE_W)'($urandom);
         write_reg(REG_OFF_CODE, {junk, c.off_code});
      end
      csr_wr_en <= 1'b0;
      settings_count++;
   endtask

   function automatic cfg_type settings(input int unsigned hmin, input int unsigned hmax,
                                        input int unsigned omin, input int unsigned omax,
                                        input int unsigned tout, input logic [7:0] on,
                                        input logic [7:0] off);
      cfg_type c;
      c.header_min   = REG_W'(hmin);
      c.header_max   = REG_W'(hmax);
      c.one_min      = REG_W'(omin);
      c.one_max      = REG_W'(omax);
      c.idle_timeout = REG_W'(tout);
      c.on_code      = on;
      c.off_code     = off;
      return c;
   endfunction

   task automatic random_settings();
      cfg_type c;
      c.header_min = REG_W'($urandom_range(6, 2));
      c.header_max = c.header_min + REG_W'($urandom_range(3, 0));
      if ($urandom_range(7, 0) == 0) c.header_max = c.header_min - REG_W'(1);
      c.one_min = REG_W'($urandom_range(3, 1));
      c.one_max = c.one_min + REG_W'($urandom_range(2, 0));
      if ($urandom_range(7, 0) == 0) c.one_max = c.one_min - REG_W'(1);
      c.idle_timeout = ((c.header_max > c.one_max) ? c.header_max : c.one_max) +
                       REG_W'($urandom_range(5, 2));
      c.on_code  = 8'($urandom);
      c.off_code = ($urandom_range(5, 0) == 0) ? c.on_code : 8'($urandom);
      apply_settings(c, 1'b0);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_frames.size() == 0) begin
            $error("result beat with no closed frame waiting");
            errors++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_frame_ok !== want.frame_ok) begin
               $error("frame_ok: expected %0d, got %0d", want.frame_ok, rsp_frame_ok);
               errors++;
            end
            if (rsp_command !== want.command) begin
               $error("command: expected 0x%02h, got 0x%02h", want.command, rsp_command);
               errors++;
            end
            if (rsp_led_on !== want.led_on) begin
               $error("led_on: expected %0d, got %0d", want.led_on, rsp_led_on);
               errors++;
            end
         end
         rsp_hold = steady ? 0 : $urandom_range(4, 0);
      end
      if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      #2_000_000;
      $error("run did not finish in time");
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // timing compressed, led codes left at their reset values
      apply_settings(settings(3, 5, 2, 3, 32'(FULL_TAIL), ON_CODE_RST, OFF_CODE_RST), 1'b1);
      for (int r = 0; r < DIRECTED_ROWS; r++) begin
         steady = ($urandom_range(2, 0) == 0);
         send_frame(32'(DIRECTED[r].hdr), 32'(DIRECTED[r].n_iv), DIRECTED[r].cmd,
                    32'(DIRECTED[r].tail));
         if (DIRECTED[r].known) begin
            if (pending_frames.size() == 0 || pending_frames[$] !== DIRECTED[r].want) begin
               $error("directed row %0d: predicted frame differs from the table", r);
               errors++;
            end
         end
      end

      // every window open, all bits read as one
      apply_settings(settings(0, 20'hFFFFF, 0, 20'hFFFFF, 4, 8'hFF, 8'h00), 1'b0);
      random_frame();
      // empty windows and clashing codes
      apply_settings(settings(20, 19, 6, 5, 7, 8'h33, 8'h33), 1'b0);
      random_frame();
      apply_settings(settings(3, 5, 2, 3, 7, 8'h5A, 8'h5A), 1'b0);
      repeat (2) random_frame();
      // zero and unit timeouts close on the tick after every opening edge
      apply_settings(settings(3, 5, 2, 3, 0, 8'h81, 8'h18), 1'b0);
      noise_burst();
      apply_settings(settings(3, 5, 2, 3, 1, 8'h81, 8'h18), 1'b0);
      noise_burst();
      // longest timeout leaves the frame open across the next settings change
      apply_settings(settings(3, 5, 2, 3, 20'hFFFFF, 8'hA5, 8'h5A), 1'b0);
      send_frame(4, 32'(FULL_FRAME), 8'hA5, 12);
      apply_settings(settings(3, 5, 2, 3, 6, 8'hA5, 8'h5A), 1'b0);
      noise_burst();

      do begin
         random_settings();
         repeat ($urandom_range(4, 2)) begin
            steady = ($urandom_range(3, 0) == 0);
            if ($urandom_range(9, 0) == 0) begin
               noise_burst();
            end else begin
               random_frame();
            end
         end
      end while (ticks_sent < TICK_GOAL);

      req_valid <= 1'b0;
      while (pending_frames.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (pending_frames.size() != 0) begin
         $error("%0d closed frames never came out", pending_frames.size());
         errors++;
      end
      $display("%0d ticks sent, %0d frames closed (%0d with a good header)",
               ticks_sent, frames_closed, frames_good);
      $display("across %0d register settings with random stalls on both channels",
               settings_count);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+design
design/ircd_pkg.sv
design/ircd_csr.sv
design/ircd_frame.sv
design/ircd_rsp_buf.sv
design/ir_pulse_distance_command_decoder.sv
verif/ir_pulse_distance_command_decoder_tb.sv
